[rtl/awb_pkg.sv]
// Types, constants and helpers shared by the affine warp bilinear block.
// Depends on nothing; every rtl file but awb_ram imports it.
package awb_pkg;

  localparam int MaxCols = 256;
  localparam int MaxRows = 256;
  localparam int WeightBits = 8;
  localparam int ColBits = $clog2(MaxCols);
  localparam int RowBits = $clog2(MaxRows);
  localparam int AddrBits = ColBits + RowBits;
  localparam int StoreDepth = MaxCols * MaxRows;
  localparam int PixBits = 32;
  localparam int QueueDepth = 4;
  localparam int QueuePtrBits = $clog2(QueueDepth);
  localparam int WBits = WeightBits + 1;
  localparam int ProdBits = 2 * WeightBits + 2;
  localparam int AccBits = 2 * WeightBits + 10;

  localparam logic [2:0] RegCoefXx = 3'd0;
  localparam logic [2:0] RegCoefXy = 3'd1;
  localparam logic [2:0] RegCoefYx = 3'd2;
  localparam logic [2:0] RegCoefYy = 3'd3;
  localparam logic [2:0] RegOffsetX = 3'd4;
  localparam logic [2:0] RegOffsetY = 3'd5;
  localparam logic [2:0] RegSourceCols = 3'd6;
  localparam logic [2:0] RegSourceRows = 3'd7;

  typedef enum logic {CMD_WRITE = 1'b0, CMD_RENDER = 1'b1} cmd_t;

  typedef struct packed {
    logic       command;
    logic [11:0] row;
    logic [11:0] col;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       covered;
  } out_item_t;

  // one classified render job passed from front to back
  typedef struct packed {
    logic                  covered;
    logic [RowBits-1:0]    iy;
    logic [ColBits-1:0]    ix;
    logic [RowBits-1:0]    iy2;
    logic [ColBits-1:0]    ix2;
    logic [WeightBits-1:0] fx;
    logic [WeightBits-1:0] fy;
  } job_t;

  typedef struct packed {
    logic [31:0] coef_xx;
    logic [31:0] coef_xy;
    logic [31:0] coef_yx;
    logic [31:0] coef_yy;
    logic [31:0] offset_x;
    logic [31:0] offset_y;
    logic [8:0]  source_cols;
    logic [8:0]  source_rows;
  } cfg_t;

endpackage

[rtl/awb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module awb_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/awb_front.sv]
// Front end: maps render coordinates through the inverse matrix and classifies.
// Depends on awb_pkg. Three pipeline stages, stalls as one on hold.
module awb_front import awb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_vld,
  input  logic [11:0] in_col,
  input  logic [11:0] in_row,
  input  logic        hold,
  output logic        busy,
  output logic        job_vld,
  output job_t        job
);

  logic        v1_r, v2_r, v3_r;
  logic [44:0] pxc_r, pxr_r, pyc_r, pyr_r;
  logic [46:0] sx_r, sy_r;
  job_t        job_r;
  logic [8:0]  cols, rows;
  logic [46:0] sx_nxt, sy_nxt;
  logic [30:0] ixw, iyw;
  logic [9:0]  ixp1, iyp1;
  logic        in_bounds;
  job_t        job_nxt;

  assign cols = (cfg.source_cols > 9'(MaxCols)) ? 9'(MaxCols) : cfg.source_cols;
  assign rows = (cfg.source_rows > 9'(MaxRows)) ? 9'(MaxRows) : cfg.source_rows;

  always_ff @(posedge clk) begin
    if (!hold) begin
      pxc_r <= 45'($signed(cfg.coef_xx) * $signed({1'b0, in_col}));
      pxr_r <= 45'($signed(cfg.coef_xy) * $signed({1'b0, in_row}));
      pyc_r <= 45'($signed(cfg.coef_yx) * $signed({1'b0, in_col}));
      pyr_r <= 45'($signed(cfg.coef_yy) * $signed({1'b0, in_row}));
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
      job_r <= job_nxt;
    end
  end

  assign sx_nxt = 47'($signed(pxc_r)) + 47'($signed(pxr_r)) + 47'($signed(cfg.offset_x));
  assign sy_nxt = 47'($signed(pyc_r)) + 47'($signed(pyr_r)) + 47'($signed(cfg.offset_y));

  assign ixw = sx_r[46:16];
  assign iyw = sy_r[46:16];
  assign in_bounds = !sx_r[46] && !sy_r[46] && (ixw < 31'(cols)) && (iyw < 31'(rows));
  assign ixp1 = 10'(ixw[ColBits-1:0]) + 10'd1;
  assign iyp1 = 10'(iyw[RowBits-1:0]) + 10'd1;

  always_comb begin
    job_nxt.covered = in_bounds;
    job_nxt.ix  = ixw[ColBits-1:0];
    job_nxt.iy  = iyw[RowBits-1:0];
    job_nxt.ix2 = (ixp1 < 10'(cols)) ? ixp1[ColBits-1:0] : ColBits'(cols - 9'd1);
    job_nxt.iy2 = (iyp1 < 10'(rows)) ? iyp1[RowBits-1:0] : RowBits'(rows - 9'd1);
    job_nxt.fx  = sx_r[15 -: WeightBits];
    job_nxt.fy  = sy_r[15 -: WeightBits];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (!hold) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign job_vld = v3_r;
  assign job     = job_r;
  assign busy    = v1_r || v2_r || v3_r;

endmodule

[rtl/awb_queue.sv]
// Short job queue between front and back ends.
// Depends on awb_pkg.
module awb_queue import awb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic nonempty,
  output job_t head,
  output logic [QueuePtrBits:0] count
);

  job_t slot_r [QueueDepth];
  logic [QueuePtrBits-1:0] wp_r, rp_r;
  logic [QueuePtrBits:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QueuePtrBits+1)'(push) - (QueuePtrBits+1)'(pop);
    end
  end

  assign nonempty = cnt_r != '0;
  assign head     = slot_r[rp_r];
  assign count    = cnt_r;

endmodule

[rtl/awb_back.sv]
// Back end: fetches four neighbors from banked source stores and blends them.
// Depends on awb_pkg and awb_ram. Four banks split by row and column parity.
module awb_back import awb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  in_item_t  wr_item,
  input  logic      job_vld,
  input  job_t      job,
  output logic      job_take,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int BankAddrBits = AddrBits - 2;
  localparam int BankDepth = StoreDepth / 4;

  logic                    adv;
  logic                    f_v_r, b_v_r, o_v_r;
  job_t                    f_job_r;
  logic [3:0][WBits-1:0]   dummy;
  logic [PixBits-1:0]      rd [4];
  logic [BankAddrBits-1:0] ra [4];
  logic [PixBits-1:0]      p [4];
  logic [ProdBits-1:0]     w_r [4];
  logic [ProdBits-1:0]     wn [4];
  logic [AccBits-1:0]      acc [4];
  logic [7:0]              ch [4];
  out_item_t               o_r;
  logic                    wr_ok;
  logic [1:0]              wbank;
  logic [BankAddrBits-1:0] waddr;
  logic [WBits-1:0]        fx1, fx0, fy1, fy0;
  logic [RowBits-1:0]      ry [2];
  logic [ColBits-1:0]      rx [2];

  assign adv      = !o_v_r || out_ready;
  assign job_take = adv && job_vld;

  assign wr_ok = (wr_item.col < 12'(MaxCols)) && (wr_item.row < 12'(MaxRows));
  assign wbank = {wr_item.row[0], wr_item.col[0]};
  assign waddr = {wr_item.row[RowBits-1:1], wr_item.col[ColBits-1:1]};

  // bank b = {row parity, col parity}; pick the neighbor row/col of each parity
  assign ry[0] = job.iy[0] ? job.iy2 : job.iy;
  assign ry[1] = job.iy[0] ? job.iy : job.iy2;
  assign rx[0] = job.ix[0] ? job.ix2 : job.ix;
  assign rx[1] = job.ix[0] ? job.ix : job.ix2;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    assign ra[b] = {ry[b/2][RowBits-1:1], rx[b%2][ColBits-1:1]};
    awb_ram #(.Width(PixBits), .Depth(BankDepth)) u_ram (
      .clk  (clk),
      .we   (wr_en && wr_ok && wbank == 2'(b)),
      .waddr(waddr),
      .wdata({wr_item.alpha_in, wr_item.blue_in, wr_item.green_in, wr_item.red_in}),
      .re   (job_take),
      .raddr(ra[b]),
      .rdata(rd[b])
    );
  end

  assign dummy = '0;

  always_ff @(posedge clk) begin
    if (job_take) f_job_r <= job;
  end

  // route banks back to neighbor order: 0 (iy,ix) 1 (iy,ix2) 2 (iy2,ix) 3 (iy2,ix2)
  always_comb begin
    p[0] = rd[{f_job_r.iy[0], f_job_r.ix[0]}];
    p[1] = rd[{f_job_r.iy[0], f_job_r.ix2[0]}];
    p[2] = rd[{f_job_r.iy2[0], f_job_r.ix[0]}];
    p[3] = rd[{f_job_r.iy2[0], f_job_r.ix2[0]}];
    fx1 = WBits'(f_job_r.fx);
    fy1 = WBits'(f_job_r.fy);
    fx0 = WBits'(1 << WeightBits) - fx1;
    fy0 = WBits'(1 << WeightBits) - fy1;
    wn[0] = ProdBits'(fx0 * fy0);
    wn[1] = ProdBits'(fx1 * fy0);
    wn[2] = ProdBits'(fx0 * fy1);
    wn[3] = ProdBits'(fx1 * fy1);
  end

  logic [PixBits-1:0] p_r [4];
  logic               b_cov_r;

  always_ff @(posedge clk) begin
    if (adv && f_v_r) begin
      for (int k = 0; k < 4; k++) begin
        p_r[k] <= p[k];
        w_r[k] <= wn[k] | ProdBits'(dummy[k]);
      end
      b_cov_r <= f_job_r.covered;
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      acc[c] = AccBits'(1 << (2 * WeightBits - 1));
      for (int k = 0; k < 4; k++) begin
        acc[c] = acc[c] + AccBits'(p_r[k][8*c +: 8] * w_r[k]);
      end
      acc[c] = acc[c] >> (2 * WeightBits);
      ch[c]  = (acc[c] > AccBits'(255)) ? 8'd255 : acc[c][7:0];
      if (!b_cov_r) ch[c] = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && b_v_r) begin
      o_r.red_out   <= ch[0];
      o_r.green_out <= ch[1];
      o_r.blue_out  <= ch[2];
      o_r.alpha_out <= ch[3];
      o_r.covered   <= b_cov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
      b_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else if (adv) begin
      f_v_r <= job_take;
      b_v_r <= f_v_r;
      o_v_r <= b_v_r;
    end
  end

  assign out_valid = o_v_r;
  assign out_data  = o_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (o_v_r && !out_ready) |=> o_v_r)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    (o_v_r && !out_ready) |=> $stable(o_r))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    (o_v_r && !o_r.covered) |-> (o_r.red_out == 8'd0 && o_r.alpha_out == 8'd0))
    else $error("uncovered result not transparent");

endmodule

[rtl/affine_warp_bilinear.sv]
// Affine warp with bilinear interpolation, top level.
// Render path: 3 front, 1 queue and 3 back registers from accept to a valid result.
// Throughput: one item per cycle unless held; writes wait for earlier renders' store reads.
// Reset: synchronous active-low; config returns to identity, 256x256; store undefined.
// Depends on awb_pkg, awb_front, awb_queue, awb_back, awb_ram.
module affine_warp_bilinear import awb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t cfg_r;
  logic in_acc, rnd, hold, f_vld, f_busy, q_ne, take;
  job_t f_job, q_head;
  logic [QueuePtrBits:0] q_cnt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coef_xx <= 32'd65536;
      cfg_r.coef_xy <= '0;
      cfg_r.coef_yx <= '0;
      cfg_r.coef_yy <= 32'd65536;
      cfg_r.offset_x <= '0;
      cfg_r.offset_y <= '0;
      cfg_r.source_cols <= 9'd256;
      cfg_r.source_rows <= 9'd256;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegCoefXx:     cfg_r.coef_xx <= cfg_data;
        RegCoefXy:     cfg_r.coef_xy <= cfg_data;
        RegCoefYx:     cfg_r.coef_yx <= cfg_data;
        RegCoefYy:     cfg_r.coef_yy <= cfg_data;
        RegOffsetX:    cfg_r.offset_x <= cfg_data;
        RegOffsetY:    cfg_r.offset_y <= cfg_data;
        RegSourceCols: cfg_r.source_cols <= cfg_data[8:0];
        RegSourceRows: cfg_r.source_rows <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // hold the front when the queue could overflow with jobs in flight
  assign hold     = q_cnt >= (QueuePtrBits+1)'(QueueDepth - 1) && !take;
  // hold a write until every render ahead of it has read the store
  assign in_ready = !hold && !(in_data.command == CMD_WRITE && (f_busy || q_ne));
  assign in_acc   = in_valid && in_ready;
  assign rnd      = in_acc && in_data.command == CMD_RENDER;

  awb_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_vld(rnd), .in_col(in_data.col), .in_row(in_data.row),
    .hold(hold), .busy(f_busy), .job_vld(f_vld), .job(f_job)
  );

  awb_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(f_vld && !hold), .push_job(f_job),
    .pop(take), .nonempty(q_ne), .head(q_head), .count(q_cnt)
  );

  awb_back u_back (
    .clk(clk), .rst_n(rst_n),
    .wr_en(in_acc && in_data.command == CMD_WRITE), .wr_item(in_data),
    .job_vld(q_ne), .job(q_head), .job_take(take),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt <= (QueuePtrBits+1)'(QueueDepth))
    else $error("job queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (q_cnt == '0) |-> !take)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    (f_vld && hold) |=> f_vld)
    else $error("front job lost on hold");

endmodule

[test/affine_warp_bilinear_checker.sv]
// Checker for the affine warp bilinear block: watches the item, result and register channels,
// keeps its own register copy and source image, predicts every render and compares results.
// Depends on awb_pkg.
`timescale 1ns / 1ps

module affine_warp_bilinear_checker import awb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          outstanding,
  output int          renders,
  output int          covered_renders,
  output int          pixel_writes
);

  logic signed [31:0] m_xx, m_xy, m_yx, m_yy, m_ox, m_oy;
  logic [8:0]         m_cols, m_rows;
  logic [31:0]        image [StoreDepth];
  out_item_t          pixel_q[$];

  initial begin
    for (int i = 0; i < StoreDepth; i++) image[i] = '0;
    mismatches = 0;
    outstanding = 0;
    renders = 0;
    covered_renders = 0;
    pixel_writes = 0;
  end

  function automatic out_item_t warp_pixel(input logic [11:0] row, input logic [11:0] col);
    out_item_t   res;
    longint      sx, sy;
    int          cols, rows, ix, iy, ix2, iy2, fx, fy, acc;
    logic [31:0] p [4];
    int          w [4];
    res = '0;
    cols = (m_cols > MaxCols) ? MaxCols : int'(m_cols);
    rows = (m_rows > MaxRows) ? MaxRows : int'(m_rows);
    sx = longint'(m_xx) * longint'(col) + longint'(m_xy) * longint'(row) + longint'(m_ox);
    sy = longint'(m_yx) * longint'(col) + longint'(m_yy) * longint'(row) + longint'(m_oy);
    if (sx < 0 || sy < 0 || sx >= (longint'(cols) <<< 16) || sy >= (longint'(rows) <<< 16))
      return res;
    ix = int'(sx >>> 16);
    iy = int'(sy >>> 16);
    fx = int'(sx[15:8]);
    fy = int'(sy[15:8]);
    ix2 = (ix + 1 < cols) ? ix + 1 : cols - 1;
    iy2 = (iy + 1 < rows) ? iy + 1 : rows - 1;
    p[0] = image[iy * MaxCols + ix];
    p[1] = image[iy * MaxCols + ix2];
    p[2] = image[iy2 * MaxCols + ix];
    p[3] = image[iy2 * MaxCols + ix2];
    w[0] = (256 - fx) * (256 - fy);
    w[1] = fx * (256 - fy);
    w[2] = (256 - fx) * fy;
    w[3] = fx * fy;
    for (int ch = 0; ch < 4; ch++) begin
      acc = 32768;
      for (int k = 0; k < 4; k++) acc += int'((p[k] >> (8 * ch)) & 32'hff) * w[k];
      acc = acc >> 16;
      if (acc > 255) acc = 255;
      case (ch)
        0: res.red_out = acc[7:0];
        1: res.green_out = acc[7:0];
        2: res.blue_out = acc[7:0];
        default: res.alpha_out = acc[7:0];
      endcase
    end
    res.covered = 1'b1;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      m_xx <= 32'sh10000;
      m_xy <= '0;
      m_yx <= '0;
      m_yy <= 32'sh10000;
      m_ox <= '0;
      m_oy <= '0;
      m_cols <= 9'd256;
      m_rows <= 9'd256;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegCoefXx:     m_xx <= cfg_data;
          RegCoefXy:     m_xy <= cfg_data;
          RegCoefYx:     m_yx <= cfg_data;
          RegCoefYy:     m_yy <= cfg_data;
          RegOffsetX:    m_ox <= cfg_data;
          RegOffsetY:    m_oy <= cfg_data;
          RegSourceCols: m_cols <= cfg_data[8:0];
          default:       m_rows <= cfg_data[8:0];
        endcase
      end
      if (in_valid && in_ready) begin
        if (cmd_t'(in_data.command) == CMD_WRITE) begin
          if (in_data.col < MaxCols && in_data.row < MaxRows) begin
            image[in_data.row * MaxCols + in_data.col] =
              {in_data.alpha_in, in_data.blue_in, in_data.green_in, in_data.red_in};
            pixel_writes++;
          end
        end else begin
          pixel_q.push_back(warp_pixel(in_data.row, in_data.col));
          renders++;
        end
      end
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("checker: unexpected result %h", out_data);
        end else begin
          out_item_t want;
          want = pixel_q.pop_front();
          if (want.covered) covered_renders++;
          if (want != out_data) begin
            mismatches++;
            if (mismatches <= 10)
              $display("checker: expected r%h g%h b%h a%h c%b, got r%h g%h b%h a%h c%b",
                       want.red_out, want.green_out, want.blue_out, want.alpha_out,
                       want.covered, out_data.red_out, out_data.green_out,
                       out_data.blue_out, out_data.alpha_out, out_data.covered);
          end
        end
      end
      outstanding = pixel_q.size();
    end
  end

endmodule

[test/affine_warp_bilinear_tb.sv]
// Testbench top for affine_warp_bilinear: clock, reset, register phases and item stimulus.
// Prediction and comparison live in affine_warp_bilinear_checker; depends on awb_pkg.
`timescale 1ns / 1ps

module affine_warp_bilinear_tb;
  import awb_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int DrainCycles = 12;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int  mismatches, outstanding, renders, covered_renders, pixel_writes;
  bit  quiet = 1'b0;
  int  stall_left = 0;
  int  cycles = 0;
  int  win;

  logic signed [31:0] t_xx = 32'sh10000, t_xy = 0, t_yx = 0, t_yy = 32'sh10000;
  logic signed [31:0] t_ox = 0, t_oy = 0;
  logic [8:0]         t_cols = 9'd256, t_rows = 9'd256;
  bit                 written [StoreDepth];

  affine_warp_bilinear uut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  affine_warp_bilinear_checker chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatches, .outstanding, .renders, .covered_renders, .pixel_writes
  );

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("affine_warp_bilinear_tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else if (!quiet && rst_n && $urandom_range(0, 9) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(1, 15);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic push(input in_item_t it);
    bit hs;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do begin
      @(negedge clk);
      hs = in_ready;
      @(posedge clk);
    end while (!hs);
  endtask

  task automatic put_pixel(input logic [11:0] row, input logic [11:0] col,
                           input logic [31:0] rgba);
    in_item_t it;
    it.command = CMD_WRITE;
    it.row = row;
    it.col = col;
    {it.alpha_in, it.blue_in, it.green_in, it.red_in} = rgba;
    if (col < MaxCols && row < MaxRows) written[row * MaxCols + col] = 1'b1;
    push(it);
  endtask

  // fill any unwritten neighbor first so a render never reads an unwritten entry
  task automatic render(input logic [11:0] row, input logic [11:0] col);
    in_item_t    it;
    longint      sx, sy;
    int          cols, rows, ix, iy, ix2, iy2;
    int          nr [4];
    int          nc [4];
    cols = (t_cols > MaxCols) ? MaxCols : int'(t_cols);
    rows = (t_rows > MaxRows) ? MaxRows : int'(t_rows);
    sx = longint'(t_xx) * longint'(col) + longint'(t_xy) * longint'(row) + longint'(t_ox);
    sy = longint'(t_yx) * longint'(col) + longint'(t_yy) * longint'(row) + longint'(t_oy);
    if (!(sx < 0 || sy < 0 || sx >= (longint'(cols) <<< 16) ||
          sy >= (longint'(rows) <<< 16))) begin
      ix = int'(sx >>> 16);
      iy = int'(sy >>> 16);
      ix2 = (ix + 1 < cols) ? ix + 1 : cols - 1;
      iy2 = (iy + 1 < rows) ? iy + 1 : rows - 1;
      nr = '{iy, iy, iy2, iy2};
      nc = '{ix, ix2, ix, ix2};
      for (int k = 0; k < 4; k++)
        if (!written[nr[k] * MaxCols + nc[k]])
          put_pixel(12'(nr[k]), 12'(nc[k]), $urandom);
    end
    it = in_item_t'({$urandom, $urandom});
    it.command = CMD_RENDER;
    it.row = row;
    it.col = col;
    push(it);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
    bit hs;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      hs = cfg_ready;
      @(posedge clk);
    end while (!hs);
    cfg_valid <= 1'b0;
    case (idx)
      RegCoefXx:     t_xx = val;
      RegCoefXy:     t_xy = val;
      RegCoefYx:     t_yx = val;
      RegCoefYy:     t_yy = val;
      RegOffsetX:    t_ox = val;
      RegOffsetY:    t_oy = val;
      RegSourceCols: t_cols = val[8:0];
      default:       t_rows = val[8:0];
    endcase
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_all(input logic [31:0] xx, xy, yx, yy, ox, oy, input logic [31:0] cols,
                         input logic [31:0] rows);
    settle();
    set_reg(RegCoefXx, xx);
    set_reg(RegCoefXy, xy);
    set_reg(RegCoefYx, yx);
    set_reg(RegCoefYy, yy);
    set_reg(RegOffsetX, ox);
    set_reg(RegOffsetY, oy);
    set_reg(RegSourceCols, cols);
    set_reg(RegSourceRows, rows);
  endtask

  function automatic logic [11:0] pick(input int lim);
    return ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, lim));
  endfunction

  task automatic random_items(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 3) put_pixel(pick(win), pick(win), $urandom);
      else render(pick(win), pick(win));
    end
  endtask

  function automatic logic [31:0] near_unit();
    return 32'($urandom_range(0, 32'h20000)) - 32'h10000;
  endfunction

  initial begin
    for (int i = 0; i < StoreDepth; i++) written[i] = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    put_pixel(12'd0, 12'd0, 32'h00000000);
    put_pixel(12'd255, 12'd255, 32'hffffffff);
    put_pixel(12'd4095, 12'd4095, 32'h5a5a5a5a);
    put_pixel(12'd0, 12'd256, 32'ha5a5a5a5);
    put_pixel(12'd256, 12'd0, 32'h12345678);
    render(12'd0, 12'd0);
    render(12'd255, 12'd255);
    render(12'd4095, 12'd4095);
    render(12'd0, 12'd256);
    render(12'd256, 12'd0);

    win = 20;
    set_all(32'h10000, 0, 0, 32'h10000, 32'h8000, 32'h4000, 16, 16);
    render(12'd15, 12'd15);
    render(12'd0, 12'd15);
    render(12'd15, 12'd0);
    random_items(130);

    win = 48;
    set_all(32'hc000, 32'($urandom_range(0, 32'h8000)) - 32'h4000,
            32'($urandom_range(0, 32'h8000)) - 32'h4000, 32'h13000,
            $urandom_range(0, 32'hfffff), $urandom_range(0, 32'hfffff),
            $urandom_range(1, 40), $urandom_range(1, 40));
    random_items(140);

    win = 60;
    set_all(near_unit(), near_unit(), near_unit(), near_unit(), 32'h140000, 32'h140000, 40, 40);
    random_items(140);

    win = 20;
    set_all(32'h10000, 0, 0, 32'h10000, 0, 0, 0, 256);
    random_items(60);
    set_all(32'h10000, 0, 0, 32'h10000, 0, 0, 256, 0);
    random_items(60);

    win = 260;
    set_all(32'h10000, 0, 0, 32'h10000, $urandom_range(0, 32'hffff),
            $urandom_range(0, 32'hffff), 511, 300);
    render(12'd255, 12'd255);
    random_items(140);

    win = 40;
    set_all(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
            32'h80000000, 256, 256);
    random_items(60);
    set_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    random_items(80);

    set_all(32'h100, 0, 0, 32'h80, 32'h10, 32'h10, 1, 1);
    random_items(100);

    win = 140;
    set_all(32'h8000, 0, 0, 32'h8000, $urandom_range(0, 32'hffff),
            $urandom_range(0, 32'hffff), 64, 64);
    random_items(100);
    quiet = 1'b1;
    random_items(120);

    settle();
    $display("run: %0d renders (%0d covered), %0d stored pixels, 10 register phases",
             renders, covered_renders, pixel_writes);
    if (mismatches == 0 && outstanding == 0)
      $display("affine_warp_bilinear_tb: clean");
    else
      $display("affine_warp_bilinear_tb: errors");
    $finish;
  end

endmodule
